### rtl/spmq_pkg.sv
// Shared types and constants of the strict priority multi-queue.
`timescale 1ns / 1ps
package spmq_pkg;

  localparam int unsigned ClassesDef = 8;
  localparam int unsigned DepthDef   = 16;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned ClassW  = 3;
  localparam int unsigned CfgW    = 4;
  localparam int unsigned TdataW  = 40;
  localparam int unsigned PadW    = TdataW - ValueW - ClassW;

  localparam logic [CfgW-1:0] NumClassesRst = 4'd8;

  typedef enum logic {
    OpEnq = 1'b0,
    OpDeq = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StBadClass = 2'd1,
    StFull     = 2'd2,
    StEmpty    = 2'd3
  } status_e;

  typedef struct packed {
    logic              deq;
    status_e           status;
    logic [ClassW-1:0] cls;
  } result_t;

endpackage

### rtl/spmq_store.sv
// Word store: one synchronous memory holding every class ring.
`timescale 1ns / 1ps
module spmq_store #(
  parameter int unsigned WORDS = 128,
  parameter int unsigned AW    = 7
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               addr_i,
  input  logic [spmq_pkg::ValueW-1:0] wdata_i,
  output logic [spmq_pkg::ValueW-1:0] rdata_o
);

  logic [spmq_pkg::ValueW-1:0] mem_q [WORDS];
  logic [spmq_pkg::ValueW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/spmq_ctrl.sv
// Queue control: per-class head and count, class arbitration, memory addressing.
`timescale 1ns / 1ps
module spmq_ctrl #(
  parameter int unsigned CLASSES = spmq_pkg::ClassesDef,
  parameter int unsigned DEPTH   = spmq_pkg::DepthDef,
  parameter int unsigned AW      = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_i,
  input  logic                        op_i,
  input  logic [spmq_pkg::ClassW-1:0] cls_i,
  input  logic [spmq_pkg::CfgW-1:0]   num_classes_i,
  output spmq_pkg::result_t           result_o,
  output logic                        mem_we_o,
  output logic                        mem_re_o,
  output logic [AW-1:0]               mem_addr_o
);

  localparam int unsigned CW = (CLASSES > 1) ? $clog2(CLASSES) : 1;
  localparam int unsigned SW = $clog2(DEPTH);
  localparam int unsigned NW = $clog2(DEPTH + 1);
  localparam logic [6:0]    ClassesLim = 7'(CLASSES);
  localparam logic [NW-1:0] DepthCnt   = NW'(DEPTH);
  localparam logic [SW:0]   DepthWrap  = (SW + 1)'(DEPTH);
  localparam logic [SW-1:0] LastSlot   = SW'(DEPTH - 1);

  logic [SW-1:0] head_q  [CLASSES];
  logic [SW-1:0] head_d  [CLASSES];
  logic [NW-1:0] count_q [CLASSES];
  logic [NW-1:0] count_d [CLASSES];

  logic [6:0]         used;
  logic               enq_valid;
  logic [CW-1:0]      enq_idx;
  logic               enq_full;
  logic [CLASSES-1:0] nonempty;
  logic [CW-1:0]      deq_idx;
  logic               deq_found;
  logic [SW:0]        slot_sum;
  logic [SW-1:0]      enq_slot;
  logic [SW-1:0]      deq_head;
  logic [CW-1:0]      sel_idx;
  logic [SW-1:0]      sel_slot;

  always_comb begin
    used = ({3'b000, num_classes_i} > ClassesLim) ? ClassesLim : {3'b000, num_classes_i};
    enq_valid = ({4'b0000, cls_i} < used);
    enq_idx   = CW'(cls_i);
    enq_full  = enq_valid && (count_q[enq_idx] == DepthCnt);

    for (int c = 0; c < CLASSES; c++) begin
      nonempty[c] = (count_q[c] != '0) && (7'(c) < used);
    end
    deq_idx   = '0;
    deq_found = 1'b0;
    for (int c = CLASSES - 1; c >= 0; c--) begin
      if (nonempty[c]) begin
        deq_idx   = CW'(c);
        deq_found = 1'b1;
      end
    end

    slot_sum = (SW + 1)'(head_q[enq_idx]) + (SW + 1)'(count_q[enq_idx]);
    enq_slot = (slot_sum >= DepthWrap) ? SW'(slot_sum - DepthWrap) : SW'(slot_sum);
    deq_head = head_q[deq_idx];

    sel_idx  = (op_i == spmq_pkg::OpDeq) ? deq_idx  : enq_idx;
    sel_slot = (op_i == spmq_pkg::OpDeq) ? deq_head : enq_slot;
    mem_addr_o = AW'(sel_idx) * AW'(DEPTH) + AW'(sel_slot);

    result_o.deq = (op_i == spmq_pkg::OpDeq);
    result_o.cls = '0;
    mem_we_o = 1'b0;
    mem_re_o = 1'b0;
    for (int c = 0; c < CLASSES; c++) begin
      head_d[c]  = head_q[c];
      count_d[c] = count_q[c];
    end

    if (op_i == spmq_pkg::OpDeq) begin
      if (deq_found) begin
        result_o.status = spmq_pkg::StOk;
        result_o.cls    = spmq_pkg::ClassW'(deq_idx);
        mem_re_o        = req_i;
        if (req_i) begin
          head_d[deq_idx]  = (deq_head == LastSlot) ? '0 : deq_head + 1'b1;
          count_d[deq_idx] = count_q[deq_idx] - 1'b1;
        end
      end else begin
        result_o.status = spmq_pkg::StEmpty;
      end
    end else if (!enq_valid) begin
      result_o.status = spmq_pkg::StBadClass;
    end else if (enq_full) begin
      result_o.status = spmq_pkg::StFull;
    end else begin
      result_o.status = spmq_pkg::StOk;
      mem_we_o        = req_i;
      if (req_i) begin
        count_d[enq_idx] = count_q[enq_idx] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CLASSES; c++) begin
        head_q[c]  <= '0;
        count_q[c] <= '0;
      end
    end else begin
      for (int c = 0; c < CLASSES; c++) begin
        head_q[c]  <= head_d[c];
        count_q[c] <= count_d[c];
      end
    end
  end

endmodule

### rtl/strict_priority_multi_queue.sv
// Top level of the strict priority multi-queue.
`timescale 1ns / 1ps
// One FIFO of DEPTH words per class, class 0 served first. A word with tuser 0
// enqueues tdata[31:0] at class tdata[34:32]; tuser 1 dequeues the oldest word of
// the lowest-numbered non-empty class below num_classes. Every input word gives
// one result word: tuser carries the status (ok, bad class, full, empty), tdata
// the dequeued value and its class, zero otherwise. One item is taken per cycle
// while the output is not stalled; the result passes the synchronous read of the
// word memory and then the output register. Head and count state
// are updated at acceptance, so back-to-back items on the same class need no stall.
module strict_priority_multi_queue #(
  parameter int unsigned CLASSES = spmq_pkg::ClassesDef,
  parameter int unsigned DEPTH   = spmq_pkg::DepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [spmq_pkg::CfgW-1:0]   cfg_wdata_i,    // num_classes
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [spmq_pkg::TdataW-1:0] s_axis_tdata,   // value[31:0], priority_req[34:32]
  input  logic                        s_axis_tuser,   // operation
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [spmq_pkg::TdataW-1:0] m_axis_tdata,   // out_value[31:0], out_class[34:32]
  output logic [1:0]                  m_axis_tuser    // status
);

  localparam int unsigned WORDS = CLASSES * DEPTH;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [spmq_pkg::CfgW-1:0]   num_classes_q;
  logic                        accept;
  logic                        s1_valid_q;
  spmq_pkg::result_t           s1_res_q;
  spmq_pkg::result_t           res;
  logic                        s1_move;
  logic                        out_valid_q;
  logic [1:0]                  out_status_q;
  logic [spmq_pkg::ValueW-1:0] out_value_q;
  logic [spmq_pkg::ClassW-1:0] out_class_q;
  logic                        mem_we;
  logic                        mem_re;
  logic [AW-1:0]               mem_addr;
  logic [spmq_pkg::ValueW-1:0] mem_rdata;

  assign s1_move       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_classes_q <= spmq_pkg::NumClassesRst;
    end else if (cfg_we_i) begin
      num_classes_q <= cfg_wdata_i;
    end
  end

  spmq_ctrl #(
    .CLASSES(CLASSES),
    .DEPTH  (DEPTH),
    .AW     (AW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (accept),
    .op_i         (s_axis_tuser),
    .cls_i        (s_axis_tdata[spmq_pkg::ValueW +: spmq_pkg::ClassW]),
    .num_classes_i(num_classes_q),
    .result_o     (res),
    .mem_we_o     (mem_we),
    .mem_re_o     (mem_re),
    .mem_addr_o   (mem_addr)
  );

  spmq_store #(
    .WORDS(WORDS),
    .AW   (AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .re_i   (mem_re),
    .addr_i (mem_addr),
    .wdata_i(s_axis_tdata[spmq_pkg::ValueW-1:0]),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q <= res;
    end
    if (s1_move) begin
      out_status_q <= s1_res_q.status;
      out_class_q  <= s1_res_q.cls;
      out_value_q  <= (s1_res_q.deq && s1_res_q.status == spmq_pkg::StOk) ? mem_rdata : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {{spmq_pkg::PadW{1'b0}}, out_class_q, out_value_q};

endmodule

### rtl/spmq_checker.sv
// Port-level checks of the strict priority multi-queue, bound to the top level.
`timescale 1ns / 1ps
module spmq_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [spmq_pkg::TdataW-1:0] m_axis_tdata,
  input logic [1:0]                  m_axis_tuser
);

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result word changed");

  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != spmq_pkg::StOk) |-> m_axis_tdata == '0)
    else $error("failed operation returned nonzero data");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a held result");

endmodule

bind strict_priority_multi_queue spmq_checker u_spmq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

### tb/sv/strict_priority_multi_queue_test.sv
// Self-checking stream testbench for the strict priority multi-queue.
`timescale 1ns / 1ps
module strict_priority_multi_queue_test;
  import spmq_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxReports = 10;

  typedef struct {
    op_e              op;
    logic [31:0]      value;
    logic [ClassW-1:0] cls;
  } queue_req_t;

  typedef struct packed {
    status_e           status;
    logic [31:0]       value;
    logic [ClassW-1:0] cls;
  } dequeue_word_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [CfgW-1:0]   cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [TdataW-1:0] s_axis_tdata  = '0;
  logic              s_axis_tuser  = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [TdataW-1:0] m_axis_tdata;
  logic [1:0]        m_axis_tuser;

  queue_req_t    pending_reqs[$];
  queue_req_t    req_on_bus;
  dequeue_word_t expected_words[$];

  logic [CfgW-1:0] class_count = NumClassesRst;
  logic [31:0]     word_store[ClassesDef][DepthDef];
  int unsigned     head_slot[ClassesDef];
  int unsigned     fill_level[ClassesDef];

  bit          no_gaps = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  int unsigned words_in_flight = 0;
  int unsigned reqs_sent = 0;
  int unsigned words_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned cfg_writes = 0;
  int unsigned cycle_count = 0;
  int unsigned status_seen[4] = '{0, 0, 0, 0};

  strict_priority_multi_queue DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  function automatic int unsigned draw_gap();
    if (no_gaps || $urandom_range(0, 1) == 0) begin
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  // Apply one request to the shadow queues and return the word it produces.
  function automatic dequeue_word_t apply_queue_op(queue_req_t req);
    dequeue_word_t res;
    int unsigned   used;
    int unsigned   slot;
    res.status = StOk;
    res.value  = '0;
    res.cls    = '0;
    used = (class_count > ClassesDef) ? ClassesDef : class_count;
    if (req.op == OpEnq) begin
      if (req.cls >= used) begin
        res.status = StBadClass;
      end else if (fill_level[req.cls] >= DepthDef) begin
        res.status = StFull;
      end else begin
        slot = (head_slot[req.cls] + fill_level[req.cls]) % DepthDef;
        word_store[req.cls][slot] = req.value;
        fill_level[req.cls]++;
      end
    end else begin
      res.status = StEmpty;
      for (int unsigned c = 0; c < used; c++) begin
        if (res.status == StEmpty && fill_level[c] != 0) begin
          res.status   = StOk;
          res.value    = word_store[c][head_slot[c]];
          res.cls      = c[ClassW-1:0];
          head_slot[c] = (head_slot[c] + 1) % DepthDef;
          fill_level[c]--;
        end
      end
    end
    return res;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MaxReports) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : feed_requests
    queue_req_t next_req;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_words = {expected_words, apply_queue_op(req_on_bus)};
        reqs_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap == 0 && pending_reqs.size() != 0) begin
          next_req   = pending_reqs.pop_front();
          req_on_bus = next_req;
          words_in_flight++;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{PadW{1'b0}}, next_req.cls, next_req.value};
          s_axis_tuser  <= next_req.op;
          send_gap = draw_gap();
        end else begin
          if (send_gap != 0) begin
            send_gap--;
          end
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : check_results
    dequeue_word_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          note_mismatch($sformatf("unexpected word: status %0d value %h class %0d",
                                  m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[34:32]));
        end else begin
          want = expected_words.pop_front();
          words_in_flight--;
          words_checked++;
          status_seen[want.status]++;
          if (m_axis_tuser !== want.status || m_axis_tdata[31:0] !== want.value ||
              m_axis_tdata[34:32] !== want.cls || m_axis_tdata[TdataW-1:35] !== '0) begin
            note_mismatch($sformatf(
                "expected status %0d value %h class %0d, got status %0d value %h class %0d pad %h",
                want.status, want.value, want.cls, m_axis_tuser, m_axis_tdata[31:0],
                m_axis_tdata[34:32], m_axis_tdata[TdataW-1:35]));
          end
        end
        recv_stall = draw_gap();
      end
      if (recv_stall != 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count, words_in_flight);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic add_req(op_e op, logic [31:0] value, logic [ClassW-1:0] cls);
    queue_req_t req;
    req.op    = op;
    req.value = value;
    req.cls   = cls;
    pending_reqs = {pending_reqs, req};
  endtask

  task automatic wait_idle();
    do begin
      @(posedge clk_i);
    end while (pending_reqs.size() != 0 || words_in_flight != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_class_count(logic [CfgW-1:0] count);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    class_count = count;
    cfg_writes++;
  endtask

  function automatic logic [31:0] draw_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [ClassW-1:0] draw_class();
    int unsigned used;
    used = (class_count > ClassesDef) ? ClassesDef : class_count;
    if (used != 0 && $urandom_range(0, 4) != 0) begin
      return ClassW'($urandom_range(0, used - 1));
    end
    return ClassW'($urandom_range(0, ClassesDef - 1));
  endfunction

  // Mix bursts into one class, drain bursts and single random requests.
  task automatic add_random_reqs(int unsigned total, int unsigned enq_pct);
    int unsigned added;
    int unsigned run_len;
    logic [ClassW-1:0] run_cls;
    added = 0;
    while (added < total) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          run_len = $urandom_range(4, 18);
          run_cls = draw_class();
          for (int unsigned k = 0; k < run_len; k++) begin
            add_req(OpEnq, draw_value(), run_cls);
          end
        end
        2: begin
          run_len = $urandom_range(4, 20);
          for (int unsigned k = 0; k < run_len; k++) begin
            add_req(OpDeq, $urandom(), ClassW'($urandom_range(0, ClassesDef - 1)));
          end
        end
        default: begin
          run_len = 1;
          if ($urandom_range(0, 99) < enq_pct) begin
            add_req(OpEnq, draw_value(), draw_class());
          end else begin
            add_req(OpDeq, $urandom(), ClassW'($urandom_range(0, ClassesDef - 1)));
          end
        end
      endcase
      added += run_len;
    end
  endtask

  initial begin
    logic [CfgW-1:0] settings[12];
    settings = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd2, 4'd5, 4'd9, 4'd4, 4'd7, 4'd6, 4'd8};
    for (int c = 0; c < ClassesDef; c++) begin
      head_slot[c]  = 0;
      fill_level[c] = 0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_req(OpDeq, 32'h1234_5678, 3'd5);
    add_req(OpEnq, 32'h8000_0000, 3'd0);
    add_req(OpEnq, 32'h7fff_ffff, 3'd7);
    add_req(OpEnq, 32'h5a5a_a5a5, 3'd3);
    add_req(OpDeq, 32'hffff_ffff, 3'd7);
    add_req(OpDeq, 32'h0000_0000, 3'd0);
    add_req(OpDeq, 32'h0000_0001, 3'd2);
    add_req(OpDeq, 32'h0000_0000, 3'd0);
    for (int unsigned k = 0; k < DepthDef; k++) begin
      add_req(OpEnq, ~k, 3'd6);
    end
    add_req(OpEnq, 32'hdead_beef, 3'd6);

    for (int i = 0; i < 12; i++) begin
      set_class_count(settings[i]);
      no_gaps = (i % 3 == 1);
      add_random_reqs(95, 35 + 15 * (i % 4));
    end
    no_gaps = 1'b0;

    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("%0d requests sent, %0d result words checked over %0d class-count writes",
             reqs_sent, words_checked, cfg_writes);
    $display("status mix: ok %0d, bad class %0d, full %0d, empty %0d", status_seen[StOk],
             status_seen[StBadClass], status_seen[StFull], status_seen[StEmpty]);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d words never arrived", mismatch_count, expected_words.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### strict_priority_multi_queue.f
rtl/spmq_pkg.sv
rtl/spmq_store.sv
rtl/spmq_ctrl.sv
rtl/strict_priority_multi_queue.sv
rtl/spmq_checker.sv
tb/sv/strict_priority_multi_queue_test.sv
